// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Types, constants and small functions shared by the texture tile swizzle
// blocks: payload structs, register indexes and the texel formatting helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  // Field widths
  localparam int PIXEL_W  = 32;
  localparam int ADDR_W   = 20;
  localparam int DIM_W    = 11;
  localparam int CNT_W    = 10;
  localparam int MORTON_W = 6;
  localparam int TILE_W   = ADDR_W - MORTON_W;
  localparam int CELL_W   = 3;
  localparam int HI_W     = CNT_W - CELL_W;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = DIM_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Largest image dimension and the reset dimension
  localparam logic [DIM_W-1:0] DIM_MAX   = 11'd1024;
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd64;

  // Input item
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_rgba;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [ADDR_W-1:0]  write_address;
    logic [PIXEL_W-1:0] texel_abgr;
    logic               last_pixel;
  } out_item_t;

  // Pixel with its scan position, between the scan and texel stages
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_rgba;
    logic [CNT_W-1:0]   column;
    logic [CNT_W-1:0]   row;
    logic               last_pixel;
  } scan_item_t;

  // Clamp a raw register value to 1..1024
  function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      d = DIM_MAX;
    end
    return d;
  endfunction

  // Reverse the four bytes: RGBA to ABGR
  function automatic logic [PIXEL_W-1:0] byte_reverse(input logic [PIXEL_W-1:0] p);
    return {p[7:0], p[15:8], p[23:16], p[31:24]};
  endfunction

  // Interleave three bits of x (even bits) and y (odd bits)
  function automatic logic [MORTON_W-1:0] morton3(input logic [CELL_W-1:0] x,
                                                  input logic [CELL_W-1:0] y);
    return {y[2], x[2], y[1], x[1], y[0], x[0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tts_stream_if.sv =====
// ----------------------------------------------------------------------------
// tts_stream_if
// Valid/ready stream channel with a typed payload; a transfer happens at a
// rising clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/tts_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// tts_scan_ctrl
// Configuration registers, x/y scan counters and texture pitch. Tags each
// accepted pixel with its position and the last-pixel flag in the input
// stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_scan_ctrl #(
  parameter int MAX_TEXTURE_SIZE = 1024,
  parameter int MIN_TEXTURE_SIZE = 64,
  parameter int TPR_W            = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [tts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // pixel input
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire tts_pkg::in_item_t               in_item,
  // tagged pixel toward the texel stage
  output logic                                 scan_valid,
  input  wire logic                            scan_ready,
  output tts_pkg::scan_item_t                  scan_item,
  output logic [TPR_W-1:0]                     tiles_per_row
);

  import tts_pkg::*;

  localparam int PITCH_W = (MAX_TEXTURE_SIZE > 1024) ? $clog2(MAX_TEXTURE_SIZE + 1) : DIM_W + 1;

  // Texture pitch in tiles: round width up to a power of two, clamp, divide by 8
  function automatic logic [TPR_W-1:0] pitch_tiles(input logic [DIM_W-1:0] w);
    logic [PITCH_W-1:0] p;
    p = '0;
    for (int i = DIM_W - 1; i >= 0; i--) begin
      if ((32'd1 << i) >= 32'(w)) begin
        p = PITCH_W'(32'd1 << i);
      end
    end
    if (p < PITCH_W'(MIN_TEXTURE_SIZE)) begin
      p = PITCH_W'(MIN_TEXTURE_SIZE);
    end
    if (p > PITCH_W'(MAX_TEXTURE_SIZE)) begin
      p = PITCH_W'(MAX_TEXTURE_SIZE);
    end
    return TPR_W'(p >> CELL_W);
  endfunction

  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;
  logic [CNT_W-1:0] column_count_r;
  logic [CNT_W-1:0] row_count_r;
  logic [TPR_W-1:0] tiles_per_row_r;
  logic             scan_valid_r;
  scan_item_t       scan_item_r;

  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;
  logic             row_end;
  logic             last;
  logic             in_xfer;
  logic             cfg_hit;

  // Scan position decode
  assign width_eff  = effective_dim(image_width_r);
  assign height_eff = effective_dim(image_height_r);
  assign row_end    = ({1'b0, column_count_r} + DIM_W'(1)) >= width_eff;
  assign last       = row_end && (({1'b0, row_count_r} + DIM_W'(1)) >= height_eff);

  assign in_ready = !scan_valid_r || scan_ready;
  assign in_xfer  = in_valid && in_ready;
  assign cfg_hit  = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                               (cfg_index == REG_IMAGE_HEIGHT));

  // Configuration, counters and pitch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= DIM_RESET;
      image_height_r  <= DIM_RESET;
      column_count_r  <= '0;
      row_count_r     <= '0;
      tiles_per_row_r <= pitch_tiles(DIM_RESET);
    end else if (cfg_hit) begin
      column_count_r <= '0;
      row_count_r    <= '0;
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width_r   <= cfg_wdata;
        tiles_per_row_r <= pitch_tiles(effective_dim(cfg_wdata));
      end else begin
        image_height_r  <= cfg_wdata;
        tiles_per_row_r <= pitch_tiles(width_eff);
      end
    end else if (in_xfer) begin
      if (last) begin
        column_count_r <= '0;
        row_count_r    <= '0;
      end else if (row_end) begin
        column_count_r <= '0;
        row_count_r    <= row_count_r + CNT_W'(1);
      end else begin
        column_count_r <= column_count_r + CNT_W'(1);
      end
    end
  end

  // Input stage register: hold while the texel stage stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_valid_r <= 1'b0;
    end else if (in_ready) begin
      scan_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      scan_item_r.pixel_rgba <= in_item.pixel_rgba;
      scan_item_r.column     <= column_count_r;
      scan_item_r.row        <= row_count_r;
      scan_item_r.last_pixel <= last;
    end
  end

  assign scan_valid    = scan_valid_r;
  assign scan_item     = scan_item_r;
  assign tiles_per_row = tiles_per_row_r;

  // Checks
  a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, column_count_r} < width_eff)
    else $error("column count beyond image width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_count_r} < height_eff)
    else $error("row count beyond image height");

  a_cfg_restarts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (column_count_r == '0) && (row_count_r == '0))
    else $error("register write did not restart the scan");

  a_pitch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    tiles_per_row_r != '0)
    else $error("tiles per row is zero");

endmodule

`default_nettype wire

// ===== rtl/tts_texel_stage.sv =====
// ----------------------------------------------------------------------------
// tts_texel_stage
// Forms the tiled word address and the ABGR texel for a tagged pixel and
// holds them in the result register until the receiver takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_texel_stage #(
  parameter int TPR_W = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // tagged pixel from the scan stage
  input  wire logic                 scan_valid,
  output logic                      scan_ready,
  input  wire tts_pkg::scan_item_t  scan_item,
  input  wire logic [TPR_W-1:0]     tiles_per_row,
  // result
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tts_pkg::out_item_t        out_item
);

  import tts_pkg::*;

  localparam int PROD_W = HI_W + TPR_W;
  localparam int SUM_W  = PROD_W + 1;

  logic              out_valid_r;
  out_item_t         out_item_r;
  logic [HI_W-1:0]   tile_row;
  logic [HI_W-1:0]   tile_col;
  logic [PROD_W-1:0] row_base;
  logic [SUM_W-1:0]  tile_sum;
  logic [TILE_W-1:0] tile_index;
  logic [ADDR_W-1:0] address;

  // Tile number times 64 plus the in-tile Morton offset
  assign tile_row   = scan_item.row[CNT_W-1:CELL_W];
  assign tile_col   = scan_item.column[CNT_W-1:CELL_W];
  assign row_base   = PROD_W'(tile_row) * PROD_W'(tiles_per_row);
  assign tile_sum   = SUM_W'(row_base) + SUM_W'(tile_col);
  assign tile_index = TILE_W'(tile_sum);
  assign address    = {tile_index, morton3(scan_item.column[CELL_W-1:0],
                                           scan_item.row[CELL_W-1:0])};

  assign scan_ready = !out_valid_r || out_ready;

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (scan_ready) begin
      out_valid_r <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_ready && scan_valid) begin
      out_item_r.write_address <= address;
      out_item_r.texel_abgr    <= byte_reverse(scan_item.pixel_rgba);
      out_item_r.last_pixel    <= scan_item.last_pixel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_addr_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_ready && scan_valid) |=>
      (out_item_r.write_address[0] == $past(scan_item.column[0])) &&
      (out_item_r.write_address[1] == $past(scan_item.row[0])))
    else $error("Morton offset does not follow the scan position");

  a_alpha_on_top: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_ready && scan_valid) |=>
      (out_item_r.texel_abgr[31:24] == $past(scan_item.pixel_rgba[7:0])))
    else $error("alpha byte not moved to the top of the texel");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result dropped while stalled");

endmodule

`default_nettype wire

// ===== rtl/texture_tile_swizzle_unit.sv =====
// ----------------------------------------------------------------------------
// texture_tile_swizzle_unit
// Linear RGBA8 pixel stream to 8x8 Morton-tiled texture writes.
//
// Usage:
//   in_stream  takes one RGBA pixel per transfer, row-major, left to right
//              then top to bottom. Each pixel yields one result on out_stream:
//              the tiled word address, the ABGR texel and a last-pixel flag.
//   cfg_*      writes image_width (index 0) or image_height (index 1); each
//              write restarts the scan at the top-left corner and recomputes
//              the texture pitch. Write only while no pixel is in flight.
//   Path: a pixel transferred on in_stream passes the input stage register,
//   then the result register, before it is offered on out_stream.
//   Throughput: one pixel per clock while out_stream.ready stays high; the
//   address path is one small multiply (tile row times tiles per row) and an
//   add between the two registers.
//   Reset: both dimensions return to 64, counters to zero, both stages empty.
//   Stall: the result register holds its item while out_stream.ready is low;
//   the input stage keeps accepting until both stages are full, then
//   in_stream.ready drops. After the last pixel the next image begins.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_tile_swizzle_unit #(
  parameter int MAX_TEXTURE_SIZE = 1024,
  parameter int MIN_TEXTURE_SIZE = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [tts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  tts_stream_if.sink                           in_stream,
  tts_stream_if.source                         out_stream
);

  import tts_pkg::*;

  localparam int TPR_W = $clog2(MAX_TEXTURE_SIZE / 8 + 1);

  logic             scan_valid;
  logic             scan_ready;
  scan_item_t       scan_item;
  logic [TPR_W-1:0] tiles_per_row;
  in_item_t         in_item;
  out_item_t        out_item;

  assign in_item            = in_stream.payload;
  assign out_stream.payload = out_item;

  // Scan counters, configuration and input stage
  tts_scan_ctrl #(
    .MAX_TEXTURE_SIZE (MAX_TEXTURE_SIZE),
    .MIN_TEXTURE_SIZE (MIN_TEXTURE_SIZE),
    .TPR_W            (TPR_W)
  ) u_scan_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_stream.valid),
    .in_ready      (in_stream.ready),
    .in_item       (in_item),
    .scan_valid    (scan_valid),
    .scan_ready    (scan_ready),
    .scan_item     (scan_item),
    .tiles_per_row (tiles_per_row)
  );

  // Address and texel formatting, result register
  tts_texel_stage #(
    .TPR_W (TPR_W)
  ) u_texel_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .scan_valid    (scan_valid),
    .scan_ready    (scan_ready),
    .scan_item     (scan_item),
    .tiles_per_row (tiles_per_row),
    .out_valid     (out_stream.valid),
    .out_ready     (out_stream.ready),
    .out_item      (out_item)
  );

endmodule

`default_nettype wire

// ===== test/texture_tile_swizzle_unit_tb.sv =====
// ----------------------------------------------------------------------------
// texture_tile_swizzle_unit_tb
// Self-checking bench for the linear-to-tiled texture swizzle. A scoreboard
// keeps its own scan counters and pitch, predicts the tiled address, ABGR
// texel and last-pixel flag of every accepted pixel, and checks each result
// transfer in order. Directed pixels and dimensions come first, then random
// pixels over several image sizes and handshake idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_tile_swizzle_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam int MIN_TEX      = 64;
  localparam int MAX_TEX      = 1024;
  localparam int REPORT_LIMIT = 10;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 300;

  // Scan-order predictor and store of pending texel writes
  class texel_scoreboard;
    logic [DIM_W-1:0] width_raw;
    logic [DIM_W-1:0] height_raw;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic [7:0]       tiles_per_row;
    out_item_t        texel_q[$];
    int               mismatches;
    int               pixels_in;
    int               texels_out;
    int               images_done;
    int               reg_writes;

    function new();
      width_raw     = DIM_RESET;
      height_raw    = DIM_RESET;
      col           = '0;
      row           = '0;
      tiles_per_row = tiles_for_width(DIM_RESET);
    endfunction

    function int unsigned clamp_dim(input logic [DIM_W-1:0] raw);
      int unsigned v;
      v = raw;
      if (v == 0) v = 1;
      if (v > MAX_TEX) v = MAX_TEX;
      return v;
    endfunction

    // Round the width up to a power of two, clamp it, count 8-wide tiles
    function logic [7:0] tiles_for_width(input logic [DIM_W-1:0] raw);
      int unsigned w;
      int unsigned p;
      w = clamp_dim(raw);
      p = 1;
      while (p < w) p = p << 1;
      if (p < MIN_TEX) p = MIN_TEX;
      if (p > MAX_TEX) p = MAX_TEX;
      return 8'(p >> 3);
    endfunction

    function int pending();
      return texel_q.size();
    endfunction

    function void flag(input string what, input longint unsigned exp_v,
                       input longint unsigned got_v);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("MISMATCH %s at texel %0d: expected 0x%0h, got 0x%0h",
                 what, texels_out, exp_v, got_v);
      end
    endfunction

    // Any register write restarts the scan at the top-left corner
    function void write_register(input cfg_reg_t idx, input logic [DIM_W-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:  width_raw = value;
        REG_IMAGE_HEIGHT: height_raw = value;
        default: return;
      endcase
      reg_writes++;
      col           = '0;
      row           = '0;
      tiles_per_row = tiles_for_width(width_raw);
    endfunction

    // Predict the texel write of one accepted pixel and advance the scan
    function void note_pixel(input logic [PIXEL_W-1:0] px);
      out_item_t           t;
      int unsigned         w;
      int unsigned         h;
      int unsigned         tile;
      logic [MORTON_W-1:0] morton_bits;
      logic                row_end;
      w = clamp_dim(width_raw);
      h = clamp_dim(height_raw);
      for (int b = 0; b < 3; b++) begin
        morton_bits[2*b]   = col[b];
        morton_bits[2*b+1] = row[b];
      end
      tile = (32'(row) >> 3) * 32'(tiles_per_row) + (32'(col) >> 3);
      t.write_address = ADDR_W'((tile << 6) + 32'(morton_bits));
      t.texel_abgr    = {<<8{px}};
      row_end         = (32'(col) + 1 >= w);
      t.last_pixel    = row_end && (32'(row) + 1 >= h);
      if (t.last_pixel) begin
        col = '0;
        row = '0;
        images_done++;
      end else if (row_end) begin
        col = '0;
        row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
      texel_q = {texel_q, t};
      pixels_in++;
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(input out_item_t got);
      out_item_t t;
      texels_out++;
      if (texel_q.size() == 0) begin
        flag("texel with nothing pending, address", 0, got.write_address);
        return;
      end
      t = texel_q.pop_front();
      if (got.write_address !== t.write_address)
        flag("write_address", t.write_address, got.write_address);
      if (got.texel_abgr !== t.texel_abgr)
        flag("texel_abgr", t.texel_abgr, got.texel_abgr);
      if (got.last_pixel !== t.last_pixel)
        flag("last_pixel", t.last_pixel, got.last_pixel);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  tts_stream_if #(.payload_t(in_item_t))  in_if ();
  tts_stream_if #(.payload_t(out_item_t)) out_if ();

  texel_scoreboard texel_sb;
  int              src_idle_pct;
  int              sink_stall_pct;
  bit              long_hold_req;
  int              quiet_cycles;

  texture_tile_swizzle_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Observe register writes and transfers on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) texel_sb.write_register(cfg_index, cfg_wdata);
      if (in_if.valid && in_if.ready) texel_sb.note_pixel(in_if.payload.pixel_rgba);
      if (out_if.valid && out_if.ready) texel_sb.check_result(out_if.payload);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) begin
          out_if.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        @(posedge clk);
      end
    end
  end

  // Offer one pixel, idling first at random; return after its transfer
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid              <= 1'b1;
    in_if.payload.pixel_rgba <= px;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Hold the input idle until every pending texel has come out
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (texel_sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Stream random pixels; optionally pause for a full drain midway
  task automatic send_random(input int count, input int pause_at);
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) drain_results();
      send_pixel($urandom());
    end
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] dim_pick[19];
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    texel_sb       = new();
    dim_pick       = '{0, 1, 8, 9, 63, 64, 65, 127, 128, 129, 255, 256, 511, 512,
                       513, 1023, 1024, 1025, 2047};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_IMAGE_WIDTH;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    long_hold_req  = 1'b0;
    quiet_cycles   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset dimensions: byte patterns across the first tile boundary
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_00FF);
    send_pixel(32'h0000_FF00);
    send_pixel(32'h00FF_0000);
    send_pixel(32'hFF00_0000);
    send_pixel(32'h1234_5678);
    send_pixel(32'hA5A5_A5A5);
    send_pixel(32'h5A5A_5A5A);
    drain_results();

    // Zero dimensions act as one: every pixel is the last
    write_dims(11'd0, 11'd0);
    repeat (3) send_pixel($urandom());
    drain_results();

    // Small image, wrap into the next one
    write_dims(11'd3, 11'd2);
    repeat (7) send_pixel($urandom());
    drain_results();

    // Height write mid-image restarts the scan
    write_reg(REG_IMAGE_HEIGHT, 11'd5);
    repeat (3) send_pixel($urandom());
    drain_results();

    // Oversized width clamps to 1024: one full row, with a long output hold
    write_dims(11'd2047, 11'd0);
    for (int n = 0; n < 1024; n++) begin
      if (n == 100) long_hold_req = 1'b1;
      send_pixel($urandom());
    end
    drain_results();

    // Tall single-column image, sender idling, drain pause midway
    src_idle_pct = 58;
    write_dims(11'd1, 11'd2047);
    send_random(500, 250);
    drain_results();

    // Random dimensions under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        1: begin src_idle_pct = 32; sink_stall_pct = 32; end
        2: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      if ($urandom_range(1) == 0) begin
        w = dim_pick[$urandom_range(18)];
      end else begin
        w = DIM_W'($urandom_range(1, 40));
      end
      h = (phase == 3) ? 11'd1024 : DIM_W'($urandom_range(0, 6));
      write_dims(w, h);
      send_random(100, -1);
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d pixels and %0d texel writes over %0d register writes",
             texel_sb.pixels_in, texel_sb.texels_out, texel_sb.reg_writes);
    $display("Completed images: %0d; field mismatches: %0d",
             texel_sb.images_done, texel_sb.mismatches);
    if (texel_sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
